// ----- src/multi_voice_sample_mixer_core_assert.svh -----
// Assertion macros for the multi-voice sample mixer core.
// Included by the RTL files that carry concurrent assertions; depends on nothing else.
`ifndef MULTI_VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MVSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mixer assertion failed");
`define MVSM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mixer assertion failed");
`else
`define MVSM_ASSERT(label, clk, rst, prop)
`define MVSM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- src/mvsm_pkg.sv -----
// Shared types and constants of the multi-voice sample mixer core.
// Used by multi_voice_sample_mixer_core and the testbench; depends on nothing else.
package mvsm_pkg;

   localparam int MAX_VOICES  = 31;
   localparam int FRAME_WORDS = 65536;
   localparam int NSLOT       = MAX_VOICES + 1;
   localparam int VOICE_AW    = $clog2(NSLOT);
   localparam int FRAME_AW    = $clog2(FRAME_WORDS);

   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_PLAY_ONCE  = 3'd1;
   localparam logic [2:0] OP_PLAY_LOOP  = 3'd2;
   localparam logic [2:0] OP_STOP       = 3'd3;
   localparam logic [2:0] OP_STOP_ALL   = 3'd4;
   localparam logic [2:0] OP_WRITE      = 3'd5;
   localparam logic [2:0] OP_SET_REGION = 3'd6;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_MODE   = 1'd1;

   // Reciprocal of 255 scaled by 2^31, exact for magnitudes below 2^23.
   localparam logic [23:0] DIV255_RECIP = 24'h808081;
   localparam int          DIV255_SHIFT = 31;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [4:0]         voice;
      logic [7:0]         volume;
      logic [15:0]        address;
      logic [16:0]        region_frames;
      logic signed [15:0] left_data;
      logic signed [15:0] right_data;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               voice_busy;
   } rsp_type;

   typedef struct packed {
      logic [16:0] position;
      logic [7:0]  gain;
      logic        loop_en;
      logic [15:0] region_base;
      logic [16:0] region_len;
   } vstate_type;

endpackage

// ----- src/multi_voice_sample_mixer_core.sv -----
// Multi-voice stereo sample mixer: one item in, one result beat out per item. Voice state
// (position, gain, loop flag, region) lives in a 32-entry voice memory with separate read and
// write ports, and the samples in a 65536-word frame memory; both have registered reads. A
// tick walks voices 1 to voice_count through the voice memory, one voice at a time: a silent
// voice is skipped, a voice at its region end is rewound or stopped, and a sounding voice
// passes voice read, frame read, multiply by gain, scale by 1/255 and accumulate. Play and
// set-region items do a read-modify-write of the voice entry. A new request beat is taken
// while a finished result beat still waits.
// Depends on mvsm_pkg and multi_voice_sample_mixer_core_assert.svh.
`include "multi_voice_sample_mixer_core_assert.svh"

module multi_voice_sample_mixer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  mvsm_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output mvsm_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [mvsm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mvsm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_M_RD   = 9'b000000010,
      ST_M_WR   = 9'b000000100,
      ST_T_RD   = 9'b000001000,
      ST_T_LOOK = 9'b000010000,
      ST_T_MUL  = 9'b000100000,
      ST_T_DIV  = 9'b001000000,
      ST_T_ACC  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   localparam int VAW = mvsm_pkg::VOICE_AW;
   localparam int FAW = mvsm_pkg::FRAME_AW;
   localparam int NS  = mvsm_pkg::NSLOT;

   function automatic logic signed [15:0] mix_add(input logic signed [15:0] a,
                                                  input logic signed [17:0] t,
                                                  input logic clip);
      logic signed [17:0] s;
      s = 18'(a) + t;
      if (clip) begin
         if (s > 18'sd32767) begin
            return 16'sh7fff;
         end else if (s < -18'sd32768) begin
            return -16'sd32768;
         end
      end
      return s[15:0];
   endfunction

   mvsm_pkg::vstate_type         vmem [NS];
   logic [31:0]                  fmem [mvsm_pkg::FRAME_WORDS];

   state_type                    state_ff, state_in;
   mvsm_pkg::req_type            req_ff, req_in;
   logic [VAW-1:0]               k_ff, k_in;
   logic [NS-1:0]                active_ff, active_in;
   logic [NS-1:0]                written_ff, written_in;
   logic [4:0]                   voice_count_ff, voice_count_in;
   logic                         clip_ff, clip_in;
   logic signed [15:0]           acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic [7:0]                   gain_ff, gain_in;
   logic signed [24:0]           prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic [16:0]                  q_l_ff, q_l_in, q_r_ff, q_r_in;
   logic                         neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   mvsm_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [VAW-1:0]               vmem_raddr;
   mvsm_pkg::vstate_type         vmem_rdata_ff;
   logic                         vmem_rvalid_ff;
   logic                         vmem_we;
   logic [VAW-1:0]               vmem_waddr;
   mvsm_pkg::vstate_type         vmem_wdata;
   logic                         fmem_we;
   logic [FAW-1:0]               fmem_waddr;
   logic [31:0]                  fmem_wdata;
   logic [FAW-1:0]               fmem_raddr;
   logic [31:0]                  fmem_rdata_ff;

   logic [VAW-1:0]               limit;
   logic                         req_accept;
   logic                         acc_ok, cur_ok;
   mvsm_pkg::vstate_type         vword;
   logic [23:0]                  mag_l, mag_r;
   logic [47:0]                  rq_l, rq_r;
   logic signed [17:0]           term_l, term_r;
   logic                         last_voice;
   logic                         rsp_free;

   assign limit = (32'(voice_count_ff) > 32'(mvsm_pkg::MAX_VOICES)) ?
                  VAW'(mvsm_pkg::MAX_VOICES) : VAW'(voice_count_ff);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign acc_ok = (req_data.voice != 5'd0) && (32'(req_data.voice) <= 32'(limit));
   assign cur_ok = (req_ff.voice != 5'd0) && (32'(req_ff.voice) <= 32'(limit));
   assign vword  = vmem_rvalid_ff ? vmem_rdata_ff : '0;
   assign last_voice = (k_ff == limit);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign mag_l  = 24'(prod_l_ff[24] ? -prod_l_ff : prod_l_ff);
   assign mag_r  = 24'(prod_r_ff[24] ? -prod_r_ff : prod_r_ff);
   assign rq_l   = mag_l * mvsm_pkg::DIV255_RECIP;
   assign rq_r   = mag_r * mvsm_pkg::DIV255_RECIP;
   assign term_l = neg_l_ff ? -$signed({1'b0, q_l_ff}) : $signed({1'b0, q_l_ff});
   assign term_r = neg_r_ff ? -$signed({1'b0, q_r_ff}) : $signed({1'b0, q_r_ff});

   assign vmem_raddr = (state_ff == ST_M_RD) ? VAW'(req_ff.voice) : k_ff;
   assign fmem_raddr = FAW'(18'(vword.region_base) + 18'(vword.position));

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      k_in           = k_ff;
      active_in      = active_ff;
      written_in     = written_ff;
      voice_count_in = voice_count_ff;
      clip_in        = clip_ff;
      acc_l_in       = acc_l_ff;
      acc_r_in       = acc_r_ff;
      gain_in        = gain_ff;
      prod_l_in      = prod_l_ff;
      prod_r_in      = prod_r_ff;
      q_l_in         = q_l_ff;
      q_r_in         = q_r_ff;
      neg_l_in       = neg_l_ff;
      neg_r_in       = neg_r_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      vmem_we        = 1'b0;
      vmem_waddr     = k_ff;
      vmem_wdata     = vword;
      fmem_we        = 1'b0;
      fmem_waddr     = FAW'(req_data.address);
      fmem_wdata     = {req_data.right_data, req_data.left_data};

      if (csr_write_en) begin
         unique case (csr_index)
            mvsm_pkg::CSR_VOICE_COUNT: voice_count_in = csr_wdata[4:0];
            mvsm_pkg::CSR_CLIP_MODE:   clip_in = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = ST_FINISH;
               unique case (req_data.opcode)
                  mvsm_pkg::OP_TICK: begin
                     acc_l_in = '0;
                     acc_r_in = '0;
                     k_in     = VAW'(1);
                     if (limit != '0) begin
                        state_in = ST_T_RD;
                     end
                  end
                  mvsm_pkg::OP_PLAY_ONCE, mvsm_pkg::OP_PLAY_LOOP,
                  mvsm_pkg::OP_SET_REGION: begin
                     if (acc_ok) begin
                        state_in = ST_M_RD;
                     end
                  end
                  mvsm_pkg::OP_STOP: begin
                     if (acc_ok) begin
                        active_in[VAW'(req_data.voice)] = 1'b0;
                     end
                  end
                  mvsm_pkg::OP_STOP_ALL: begin
                     for (int i = 1; i < NS; i++) begin
                        if (i <= int'(limit)) begin
                           active_in[i] = 1'b0;
                        end
                     end
                  end
                  mvsm_pkg::OP_WRITE: begin
                     fmem_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_M_RD: begin
            state_in = ST_M_WR;
         end
         ST_M_WR: begin
            vmem_we    = 1'b1;
            vmem_waddr = VAW'(req_ff.voice);
            written_in[VAW'(req_ff.voice)] = 1'b1;
            if (req_ff.opcode == mvsm_pkg::OP_SET_REGION) begin
               vmem_wdata.region_base = req_ff.address;
               vmem_wdata.region_len  = req_ff.region_frames;
            end else begin
               vmem_wdata.position = '0;
               vmem_wdata.gain     = req_ff.volume;
               vmem_wdata.loop_en  = (req_ff.opcode == mvsm_pkg::OP_PLAY_LOOP);
               active_in[VAW'(req_ff.voice)] = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_T_RD: begin
            if (active_ff[k_ff]) begin
               state_in = ST_T_LOOK;
            end else if (last_voice) begin
               state_in = ST_FINISH;
            end else begin
               k_in = k_ff + VAW'(1);
            end
         end
         ST_T_LOOK: begin
            vmem_we = 1'b1;
            written_in[k_ff] = 1'b1;
            gain_in = vword.gain;
            if (vword.position >= vword.region_len) begin
               vmem_wdata.position = '0;
               vmem_we = vword.loop_en;
               if (!vword.loop_en) begin
                  active_in[k_ff] = 1'b0;
               end
               if (last_voice) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in     = k_ff + VAW'(1);
                  state_in = ST_T_RD;
               end
            end else begin
               vmem_wdata.position = vword.position + 17'd1;
               state_in = ST_T_MUL;
            end
         end
         ST_T_MUL: begin
            prod_l_in = $signed(fmem_rdata_ff[15:0]) * $signed({1'b0, gain_ff});
            prod_r_in = $signed(fmem_rdata_ff[31:16]) * $signed({1'b0, gain_ff});
            state_in  = ST_T_DIV;
         end
         ST_T_DIV: begin
            q_l_in   = rq_l[mvsm_pkg::DIV255_SHIFT +: 17];
            q_r_in   = rq_r[mvsm_pkg::DIV255_SHIFT +: 17];
            neg_l_in = prod_l_ff[24];
            neg_r_in = prod_r_ff[24];
            state_in = ST_T_ACC;
         end
         ST_T_ACC: begin
            acc_l_in = mix_add(acc_l_ff, term_l, clip_ff);
            acc_r_in = mix_add(acc_r_ff, term_r, clip_ff);
            if (last_voice) begin
               state_in = ST_FINISH;
            end else begin
               k_in     = k_ff + VAW'(1);
               state_in = ST_T_RD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (req_ff.opcode == mvsm_pkg::OP_TICK) begin
                  rsp_data_in.left_out  = acc_l_ff;
                  rsp_data_in.right_out = acc_r_ff;
               end else begin
                  rsp_data_in.left_out  = '0;
                  rsp_data_in.right_out = '0;
               end
               rsp_data_in.voice_busy = cur_ok && active_ff[VAW'(req_ff.voice)];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_ff      <= '0;
         written_ff     <= '0;
         voice_count_ff <= '0;
         clip_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         written_ff     <= written_in;
         voice_count_ff <= voice_count_in;
         clip_ff        <= clip_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      k_ff        <= k_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
      gain_ff     <= gain_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      q_l_ff      <= q_l_in;
      q_r_ff      <= q_r_in;
      neg_l_ff    <= neg_l_in;
      neg_r_ff    <= neg_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (vmem_we) begin
         vmem[vmem_waddr] <= vmem_wdata;
      end
      vmem_rdata_ff  <= vmem[vmem_raddr];
      vmem_rvalid_ff <= written_ff[vmem_raddr];
   end

   always_ff @(posedge clock) begin
      if (fmem_we) begin
         fmem[fmem_waddr] <= fmem_wdata;
      end
      fmem_rdata_ff <= fmem[fmem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MVSM_ASSERT(a_walk_in_range, clock, reset,
      (state_ff == ST_T_RD) |-> (k_ff != '0) && (32'(k_ff) <= 32'(limit)))
   `MVSM_ASSERT(a_slot_zero_silent, clock, reset, !active_ff[0])
   `MVSM_ASSERT(a_accept_takes_time, clock, reset, req_accept |=> req_stall)
   `MVSM_ASSERT(a_finish_delivers, clock, reset,
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid_ff && !req_stall)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for multi_voice_sample_mixer_core: directed steps, then random phases.
// Results are predicted by an in-bench mixer and compared beat by beat.
// Depends on mvsm_pkg and multi_voice_sample_mixer_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;
   localparam int GAIN_FULL = 255;
   localparam int PREDICT = -1;
   localparam int IDLE_PCT = 29;
   localparam int PHASE_ITEMS = 240;

   typedef struct {
      bit                              is_csr;
      logic [mvsm_pkg::CSR_IDX_W-1:0]  idx;
      logic [mvsm_pkg::CSR_DATA_W-1:0] val;
      mvsm_pkg::req_type               req;
      bit                              typed;
      mvsm_pkg::rsp_type               want;
   } mix_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mvsm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mvsm_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [mvsm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mvsm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bit [16:0] vpos [mvsm_pkg::NSLOT];
   bit [7:0] vgain [mvsm_pkg::NSLOT];
   bit vactive [mvsm_pkg::NSLOT];
   bit vloop [mvsm_pkg::NSLOT];
   bit [15:0] vbase [mvsm_pkg::NSLOT];
   bit [16:0] vlen [mvsm_pkg::NSLOT];
   bit [31:0] frame_store [mvsm_pkg::FRAME_WORDS];
   bit frame_known [mvsm_pkg::FRAME_WORDS];
   bit [4:0] voice_count_r;
   bit clip_r;

   mvsm_pkg::rsp_type frames_due[$];
   mix_row_type steps[$];
   int mismatches = 0;
   int items_sent = 0;
   bit calm = 1'b0;

   multi_voice_sample_mixer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit voice_live(logic [4:0] v);
      return v >= 1 && v <= voice_count_r;
   endfunction

   function automatic int mix_add(int acc, int term);
      int s;
      logic signed [15:0] w;
      s = acc + term;
      if (clip_r) begin
         if (s > SAMPLE_MAX) s = SAMPLE_MAX;
         if (s < SAMPLE_MIN) s = SAMPLE_MIN;
         return s;
      end
      w = s[15:0];
      return int'(w);
   endfunction

   function automatic int apply_gain(logic [15:0] sample, bit [7:0] gain);
      int x;
      x = int'($signed(sample));
      return (x * int'(gain)) / GAIN_FULL;
   endfunction

   function automatic mvsm_pkg::rsp_type mix_one_item(mvsm_pkg::req_type r);
      mvsm_pkg::rsp_type res;
      int left, right, k;
      bit [31:0] word;
      bit [15:0] a;
      left = 0;
      right = 0;
      case (r.opcode)
         mvsm_pkg::OP_TICK: begin
            for (k = 1; k <= voice_count_r; k++) begin
               if (vactive[k]) begin
                  if (vpos[k] >= vlen[k]) begin
                     if (vloop[k]) vpos[k] = '0;
                     else vactive[k] = 1'b0;
                  end else begin
                     a = vbase[k] + vpos[k][15:0];
                     word = frame_store[a];
                     left = mix_add(left, apply_gain(word[15:0], vgain[k]));
                     right = mix_add(right, apply_gain(word[31:16], vgain[k]));
                     vpos[k] = vpos[k] + 17'd1;
                  end
               end
            end
         end
         mvsm_pkg::OP_PLAY_ONCE, mvsm_pkg::OP_PLAY_LOOP: begin
            if (voice_live(r.voice)) begin
               vpos[r.voice] = '0;
               vgain[r.voice] = r.volume;
               vactive[r.voice] = 1'b1;
               vloop[r.voice] = (r.opcode == mvsm_pkg::OP_PLAY_LOOP);
            end
         end
         mvsm_pkg::OP_STOP: begin
            if (voice_live(r.voice)) vactive[r.voice] = 1'b0;
         end
         mvsm_pkg::OP_STOP_ALL: begin
            for (k = 1; k <= voice_count_r; k++) vactive[k] = 1'b0;
         end
         mvsm_pkg::OP_WRITE: begin
            frame_store[r.address] = {r.right_data, r.left_data};
            frame_known[r.address] = 1'b1;
         end
         mvsm_pkg::OP_SET_REGION: begin
            if (voice_live(r.voice)) begin
               vbase[r.voice] = r.address;
               vlen[r.voice] = r.region_frames;
            end
         end
         default: begin
         end
      endcase
      res.left_out = left[15:0];
      res.right_out = right[15:0];
      res.voice_busy = voice_live(r.voice) && vactive[r.voice];
      return res;
   endfunction

   function automatic mix_row_type item_row(logic [2:0] op, int v, int vol, int addr,
                                            int frames, int ld, int rd, int busy);
      mix_row_type row;
      row.is_csr = 1'b0;
      row.idx = '0;
      row.val = '0;
      row.req.opcode = op;
      row.req.voice = 5'(v);
      row.req.volume = 8'(vol);
      row.req.address = 16'(addr);
      row.req.region_frames = 17'(frames);
      row.req.left_data = 16'(ld);
      row.req.right_data = 16'(rd);
      row.typed = (busy != PREDICT);
      row.want = '0;
      row.want.voice_busy = (busy == 1);
      return row;
   endfunction

   function automatic mix_row_type csr_row(logic [mvsm_pkg::CSR_IDX_W-1:0] idx, int val);
      mix_row_type row;
      row = item_row(mvsm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, PREDICT);
      row.is_csr = 1'b1;
      row.idx = idx;
      row.val = mvsm_pkg::CSR_DATA_W'(val);
      return row;
   endfunction

   task automatic send_beat(mvsm_pkg::req_type r, bit typed, mvsm_pkg::rsp_type want);
      mvsm_pkg::rsp_type got;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      got = mix_one_item(r);
      frames_due.push_back(typed ? want : got);
      req_valid <= 1'b1;
      req_data <= r;
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // A tick must never read a frame that was never written, so such frames are filled first.
   task automatic drive_item(mvsm_pkg::req_type r, bit typed, mvsm_pkg::rsp_type want);
      int k;
      bit [15:0] a;
      mvsm_pkg::req_type fill;
      if (r.opcode == mvsm_pkg::OP_TICK) begin
         for (k = 1; k <= voice_count_r; k++) begin
            if (vactive[k] && vpos[k] < vlen[k]) begin
               a = vbase[k] + vpos[k][15:0];
               if (!frame_known[a]) begin
                  fill = '0;
                  fill.opcode = mvsm_pkg::OP_WRITE;
                  fill.address = a;
                  fill.left_data = 16'($urandom);
                  fill.right_data = 16'($urandom);
                  send_beat(fill, 1'b0, '0);
               end
            end
         end
      end
      send_beat(r, typed, want);
   endtask

   task automatic write_csr(logic [mvsm_pkg::CSR_IDX_W-1:0] idx,
                            logic [mvsm_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == mvsm_pkg::CSR_VOICE_COUNT) voice_count_r = val;
      else clip_r = val[0];
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      mvsm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: L %0d R %0d busy %0d",
                        rsp_data.left_out, rsp_data.right_out, rsp_data.voice_busy);
         end else begin
            want = frames_due.pop_front();
            if (rsp_data.left_out !== want.left_out || rsp_data.right_out !== want.right_out ||
                rsp_data.voice_busy !== want.voice_busy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected L %0d R %0d busy %0d, got L %0d R %0d busy %0d",
                           want.left_out, want.right_out, want.voice_busy,
                           rsp_data.left_out, rsp_data.right_out, rsp_data.voice_busy);
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      mvsm_pkg::req_type r;
      int phase, phase_end, sel, lsel, vsel;
      bit [4:0] cnt;
      bit clp;

      // Reset values first: no voice is valid, so play is ignored and a tick is silent.
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_PLAY_ONCE, 1, 255, 0, 0, 0, 0, 0));
      steps.push_back(csr_row(mvsm_pkg::CSR_VOICE_COUNT, 31));
      steps.push_back(csr_row(mvsm_pkg::CSR_CLIP_MODE, 1));
      steps.push_back(item_row(mvsm_pkg::OP_WRITE, 0, 0, 0, 0, 32767, -32768, 0));
      steps.push_back(item_row(mvsm_pkg::OP_WRITE, 0, 0, 65535, 0, -32768, 32767, 0));
      steps.push_back(item_row(mvsm_pkg::OP_WRITE, 0, 0, 1, 0, -1, 1, 0));
      // Voice 31 loops over a region that wraps past the top of frame memory.
      steps.push_back(item_row(mvsm_pkg::OP_SET_REGION, 31, 0, 65535, 3, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_PLAY_LOOP, 31, 255, 0, 0, 0, 0, 1));
      steps.push_back(item_row(mvsm_pkg::OP_SET_REGION, 1, 0, 0, 2, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_PLAY_ONCE, 1, 255, 0, 0, 0, 0, 1));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 1, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 31, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 1, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 31, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(item_row(mvsm_pkg::OP_SET_REGION, 0, 0, 5, 65536, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_SET_REGION, 4, 0, 65535, 65536, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_PLAY_ONCE, 4, 128, 0, 0, 0, 0, 1));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 4, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(item_row(mvsm_pkg::OP_STOP, 4, 0, 0, 0, 0, 0, 0));
      steps.push_back(item_row(OP_UNUSED, 31, 255, 65535, 65536, -1, -1, PREDICT));
      // Stop all with fewer voices loaded leaves voice 31 playing.
      steps.push_back(csr_row(mvsm_pkg::CSR_VOICE_COUNT, 1));
      steps.push_back(item_row(mvsm_pkg::OP_STOP_ALL, 31, 0, 0, 0, 0, 0, 0));
      steps.push_back(csr_row(mvsm_pkg::CSR_VOICE_COUNT, 31));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 31, 0, 0, 0, 0, 0, PREDICT));
      steps.push_back(csr_row(mvsm_pkg::CSR_CLIP_MODE, 0));
      steps.push_back(item_row(mvsm_pkg::OP_SET_REGION, 2, 0, 0, 1, 0, 0, 0));
      steps.push_back(item_row(mvsm_pkg::OP_PLAY_LOOP, 2, 255, 0, 0, 0, 0, 1));
      steps.push_back(item_row(mvsm_pkg::OP_TICK, 2, 0, 0, 0, 0, 0, PREDICT));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].is_csr) write_csr(steps[i].idx, steps[i].val);
         else drive_item(steps[i].req, steps[i].typed, steps[i].want);
      end

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin cnt = 31; clp = 1'b0; end
            1: begin cnt = 31; clp = 1'b1; end
            2: begin cnt = 7; clp = 1'b1; end
            3: begin cnt = 0; clp = 1'b0; end
            4: begin cnt = 1; clp = 1'b1; end
            5: begin cnt = 5'($urandom_range(2, 30)); clp = 1'b0; end
            6: begin cnt = 5'($urandom_range(2, 30)); clp = 1'b1; end
            default: begin cnt = 31; clp = 1'($urandom_range(0, 1)); end
         endcase
         write_csr(mvsm_pkg::CSR_VOICE_COUNT, cnt);
         write_csr(mvsm_pkg::CSR_CLIP_MODE, clp);
         calm = (phase == 1);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            sel = $urandom_range(0, 99);
            if (sel < 38) r.opcode = mvsm_pkg::OP_TICK;
            else if (sel < 50) r.opcode = mvsm_pkg::OP_PLAY_ONCE;
            else if (sel < 60) r.opcode = mvsm_pkg::OP_PLAY_LOOP;
            else if (sel < 70) r.opcode = mvsm_pkg::OP_SET_REGION;
            else if (sel < 80) r.opcode = mvsm_pkg::OP_WRITE;
            else if (sel < 86) r.opcode = mvsm_pkg::OP_STOP;
            else if (sel < 89) r.opcode = mvsm_pkg::OP_STOP_ALL;
            else if (sel < 92) r.opcode = OP_UNUSED;
            else r.opcode = 3'($urandom_range(0, 7));
            if (voice_count_r != 0 && $urandom_range(0, 99) < 85)
               r.voice = 5'($urandom_range(1, voice_count_r));
            else
               r.voice = 5'($urandom_range(0, 31));
            vsel = $urandom_range(0, 9);
            r.volume = (vsel == 0) ? 8'd0 : (vsel == 1) ? 8'd255 : 8'($urandom);
            if ($urandom_range(0, 99) < 75)
               r.address = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                                 : 16'($urandom_range(65472, 65535));
            else
               r.address = 16'($urandom);
            lsel = $urandom_range(0, 99);
            if (lsel < 15) r.region_frames = '0;
            else if (lsel < 70) r.region_frames = 17'($urandom_range(1, 12));
            else if (lsel < 85) r.region_frames = 17'($urandom_range(13, 300));
            else if (lsel < 95) r.region_frames = 17'($urandom_range(0, 65536));
            else r.region_frames = 17'(65535 + $urandom_range(0, 1));
            r.left_data = 16'($urandom);
            r.right_data = 16'($urandom);
            drive_item(r, 1'b0, '0);
         end
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/mvsm_pkg.sv
src/multi_voice_sample_mixer_core.sv
tb/testbench.sv
